FILE: design/rpp_pkg.sv
// Shared types, constants and helpers for the RSSI proximity pulser.
package rpp_pkg;

	localparam int unsigned AgeW = 16;
	localparam logic [AgeW-1:0] AgeMax = 16'hFFFF;
	localparam logic [AgeW-1:0] PulseLenMs = 16'd50;
	localparam logic [AgeW-1:0] PacketTimeoutMs = 16'd2500;
	localparam logic [6:0] LampBright = 7'd100;
	localparam logic [6:0] LampDim = 7'd20;
	localparam logic [6:0] LampOff = 7'd0;

	// Numerator of the period map: 9-bit magnitude times 16-bit magnitude
	localparam int unsigned DivBits = 25;
	localparam int unsigned CntW = $clog2(DivBits + 1);

	localparam int unsigned AddrW = 5;
	localparam int unsigned DataW = 32;

	typedef enum logic [2:0] {
		REG_NEAR_RSSI_LOW   = 3'd0,
		REG_NEAR_RSSI_HIGH  = 3'd1,
		REG_NEAR_PERIOD_LOW = 3'd2,
		REG_NEAR_PERIOD_HIGH = 3'd3,
		REG_FAR_RSSI_LOW    = 3'd4,
		REG_FAR_RSSI_HIGH   = 3'd5,
		REG_FAR_PERIOD_LOW  = 3'd6,
		REG_FAR_PERIOD_HIGH = 3'd7
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_AGE,
		ST_MUL,
		ST_DIV,
		ST_MAP,
		ST_DONE
	} state_t;

	function automatic logic [AgeW-1:0] age_up(input logic [AgeW-1:0] a);
		return (a == AgeMax) ? a : a + 16'd1;
	endfunction

endpackage

FILE: design/rssi_proximity_pulser.sv
// RSSI proximity pulser: packet/tick sequencer with a shared serial divider.
// Sequence: a packet item goes from idle straight to done; a tick item runs the age
// step, and when the RSSI changed and the map points differ, the multiply step, the
// 25-step restoring divider (one quotient bit per cycle) and the map step before done.
// Throughput: one item at a time; the next request is taken once the sequencer is idle.
// Reset: arst_n async loads register defaults and clears state except divider and m_tdata.
module rssi_proximity_pulser (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [15:0]                 s_tdata,  // rssi[7:0], near_select[8], loud_select[9]
	input  logic [0:0]                  s_tuser,  // mode[0]: 0 tick, 1 packet
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [23:0]                 m_tdata,  // lamp_level[6:0], sound_on[7], period_ms[23:8]
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [rpp_pkg::AddrW-1:0]   paddr,
	input  logic [rpp_pkg::DataW-1:0]   pwdata,
	output logic [rpp_pkg::DataW-1:0]   prdata,
	output logic                        pready
);
	import rpp_pkg::*;

	// configuration registers
	logic [7:0]  near_rssi_low_q, near_rssi_high_q, far_rssi_low_q, far_rssi_high_q;
	logic [15:0] near_period_low_q, near_period_high_q, far_period_low_q, far_period_high_q;

	// block state
	logic [7:0]      latest_q, seen_q;
	logic [AgeW-1:0] period_q, packet_age_q, since_q, pulse_age_q;
	logic [6:0]      lamp_q;
	logic            sound_q;

	// item and sequencer
	state_t state_q, state_d;
	logic   mode_q, near_q, loud_q;
	logic   map_neg_q;
	logic [DivBits-1:0] quo_q;
	logic [7:0]         rem_q, den_q;
	logic [CntW-1:0]    cnt_q;

	logic        m_tvalid_q;
	logic [23:0] m_tdata_q;

	logic        cfg_wr;
	reg_idx_t    cfg_idx;
	logic        accept, out_free, done_go;

	// selected sensitivity set
	logic [7:0]  r_lo, r_hi;
	logic [15:0] p_lo, p_hi;

	// tick datapath
	logic [AgeW-1:0] packet_age_up, since_up, pulse_age_up;
	logic [8:0]      rssi_mag;
	logic            changed, too_far, map_flat;
	logic [9:0]      x_neg, dx;
	logic [8:0]      dx_mag;
	logic [17:0]     dp, dp_abs;
	logic [15:0]     dp_mag;
	logic [8:0]      den, den_abs;
	logic [DivBits-1:0] product;

	// divider step
	logic [8:0] trial;
	logic       ge;

	// map result
	logic [25:0]     map_sum;
	logic [AgeW-1:0] map_res;

	// pulse start
	logic       fire;
	logic [6:0] lamp_nx;
	logic       sound_nx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign cfg_idx = reg_idx_t'(paddr[4:2]);

	always_comb begin
		case (cfg_idx)
			REG_NEAR_RSSI_LOW:    prdata = {24'd0, near_rssi_low_q};
			REG_NEAR_RSSI_HIGH:   prdata = {24'd0, near_rssi_high_q};
			REG_NEAR_PERIOD_LOW:  prdata = {16'd0, near_period_low_q};
			REG_NEAR_PERIOD_HIGH: prdata = {16'd0, near_period_high_q};
			REG_FAR_RSSI_LOW:     prdata = {24'd0, far_rssi_low_q};
			REG_FAR_RSSI_HIGH:    prdata = {24'd0, far_rssi_high_q};
			REG_FAR_PERIOD_LOW:   prdata = {16'd0, far_period_low_q};
			REG_FAR_PERIOD_HIGH:  prdata = {16'd0, far_period_high_q};
			default:              prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			near_rssi_low_q    <= 8'd30;
			near_rssi_high_q   <= 8'd80;
			near_period_low_q  <= 16'd20;
			near_period_high_q <= 16'd1500;
			far_rssi_low_q     <= 8'd70;
			far_rssi_high_q    <= 8'd200;
			far_period_low_q   <= 16'd50;
			far_period_high_q  <= 16'd2000;
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_NEAR_RSSI_LOW:    near_rssi_low_q    <= pwdata[7:0];
				REG_NEAR_RSSI_HIGH:   near_rssi_high_q   <= pwdata[7:0];
				REG_NEAR_PERIOD_LOW:  near_period_low_q  <= pwdata[15:0];
				REG_NEAR_PERIOD_HIGH: near_period_high_q <= pwdata[15:0];
				REG_FAR_RSSI_LOW:     far_rssi_low_q     <= pwdata[7:0];
				REG_FAR_RSSI_HIGH:    far_rssi_high_q    <= pwdata[7:0];
				REG_FAR_PERIOD_LOW:   far_period_low_q   <= pwdata[15:0];
				REG_FAR_PERIOD_HIGH:  far_period_high_q  <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	assign r_lo = near_q ? near_rssi_low_q    : far_rssi_low_q;
	assign r_hi = near_q ? near_rssi_high_q   : far_rssi_high_q;
	assign p_lo = near_q ? near_period_low_q  : far_period_low_q;
	assign p_hi = near_q ? near_period_high_q : far_period_high_q;

	// ages and limit tests
	always_comb begin
		packet_age_up = age_up(packet_age_q);
		since_up      = age_up(since_q);
		pulse_age_up  = age_up(pulse_age_q);
		rssi_mag      = latest_q[7] ? (9'd256 - {1'b0, latest_q}) : {1'b0, latest_q};
		too_far       = (rssi_mag > {1'b0, r_hi}) || (packet_age_up > PacketTimeoutMs);
		changed       = (latest_q != seen_q);
		map_flat      = (r_hi == r_lo);
	end

	// map operands: (x - lo) * (phi - plo) / (hi - lo), x = -rssi
	always_comb begin
		x_neg   = 10'd0 - {{2{latest_q[7]}}, latest_q};
		dx      = x_neg - {2'b00, r_lo};
		dx_mag  = dx[9] ? 9'(10'd0 - dx) : dx[8:0];
		dp      = {2'b00, p_hi} - {2'b00, p_lo};
		dp_abs  = dp[17] ? (18'd0 - dp) : dp;
		dp_mag  = dp_abs[15:0];
		den     = {1'b0, r_hi} - {1'b0, r_lo};
		den_abs = den[8] ? (9'd0 - den) : den;
		product = {16'd0, dx_mag} * {9'd0, dp_mag};
	end

	// one restoring division step
	always_comb begin
		trial = {rem_q, quo_q[DivBits-1]};
		ge    = (trial >= {1'b0, den_q});
	end

	// a negative quotient lands below period_low and clamps to it
	always_comb begin
		map_sum = {1'b0, quo_q} + 26'(p_lo);
		if (map_neg_q)
			map_res = p_lo;
		else if (map_sum[25:16] != 10'd0)
			map_res = AgeMax;
		else
			map_res = map_sum[15:0];
	end

	always_comb begin
		fire     = !mode_q && (period_q != 16'd0) && (since_q > period_q);
		lamp_nx  = fire ? (loud_q ? LampBright : LampDim) : lamp_q;
		sound_nx = fire ? loud_q : sound_q;
	end

	// sequencer: next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (accept) state_d = s_tuser[0] ? ST_DONE : ST_AGE;
			ST_AGE: begin
				if (changed && !map_flat)
					state_d = ST_MUL;
				else
					state_d = ST_DONE;
			end
			ST_MUL:  state_d = ST_DIV;
			ST_DIV:  if (cnt_q == CntW'(1)) state_d = ST_MAP;
			ST_MAP:  state_d = ST_DONE;
			ST_DONE: if (done_go) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// sequencer: outputs
	always_comb begin
		s_tready = (state_q == ST_IDLE);
		out_free = !m_tvalid_q || m_tready;
		done_go  = (state_q == ST_DONE) && out_free;
		accept   = s_tvalid && s_tready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			latest_q     <= '0;
			seen_q       <= '0;
			period_q     <= '0;
			packet_age_q <= '0;
			since_q      <= '0;
			pulse_age_q  <= '0;
			lamp_q       <= LampOff;
			sound_q      <= 1'b0;
			mode_q       <= 1'b0;
			near_q       <= 1'b0;
			loud_q       <= 1'b0;
			cnt_q        <= '0;
			map_neg_q    <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						mode_q <= s_tuser[0];
						near_q <= s_tdata[8];
						loud_q <= s_tdata[9];
						if (s_tuser[0]) begin
							latest_q     <= s_tdata[7:0];
							packet_age_q <= '0;
						end
					end
				end
				ST_AGE: begin
					packet_age_q <= packet_age_up;
					since_q      <= since_up;
					pulse_age_q  <= pulse_age_up;
					if (pulse_age_up > PulseLenMs) begin
						lamp_q  <= LampOff;
						sound_q <= 1'b0;
					end
					if (changed) begin
						seen_q <= latest_q;
						// equal map points: period goes straight to period_low
						if (map_flat)
							period_q <= p_lo;
					end else if (too_far) begin
						period_q <= '0;
					end
				end
				ST_MUL: begin
					map_neg_q <= dx[9] ^ dp[17] ^ den[8];
					cnt_q     <= CntW'(DivBits);
				end
				ST_DIV: begin
					cnt_q <= cnt_q - CntW'(1);
				end
				ST_MAP: begin
					period_q <= map_res;
				end
				ST_DONE: begin
					if (done_go) begin
						lamp_q  <= lamp_nx;
						sound_q <= sound_nx;
						if (fire) begin
							pulse_age_q <= '0;
							since_q     <= '0;
						end
					end
				end
				default: ;
			endcase
		end
	end

	// divider datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_MUL: begin
				quo_q <= product;
				rem_q <= '0;
				den_q <= den_abs[7:0];
			end
			ST_DIV: begin
				quo_q <= {quo_q[DivBits-2:0], ge};
				rem_q <= ge ? 8'(trial - {1'b0, den_q}) : trial[7:0];
			end
			default: ;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (done_go) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done_go)
			m_tdata_q <= {period_q, sound_nx, lamp_nx};
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	a_cnt_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_DIV) |-> (cnt_q == '0))
		else $error("divider count live outside the divide state");

	a_sound_bright: assert property (@(posedge clk) disable iff (!arst_n)
		sound_q |-> (lamp_q == LampBright))
		else $error("beeper on without bright lamp");

	a_lamp_level: assert property (@(posedge clk) disable iff (!arst_n)
		(lamp_q == LampOff) || (lamp_q == LampDim) || (lamp_q == LampBright))
		else $error("lamp level off the allowed set");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> (state_q != ST_IDLE))
		else $error("request taken but sequencer stayed idle");

endmodule
